>>> src/word_modular_exponentiation_top_defines.svh
// Assertion macros shared by the modular exponentiation RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef WORD_MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define WORD_MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define WME_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle
`define WME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/wme_pkg.sv
// Types and constants for the word modular exponentiation block.
// Depends on nothing; used by every module of the block but wme_mulmod.
package wme_pkg;

	localparam int FIELD_BITS = 64;

	typedef struct packed {
		logic [FIELD_BITS-1:0] base;
		logic [FIELD_BITS-1:0] exponent;
		logic [FIELD_BITS-1:0] modulus;
	} in_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] power_result;
		logic                  modulus_zero;
	} out_t;

	typedef enum logic [1:0] {
		KIND_ZERO_MOD = 2'd0,
		KIND_ZERO_EXP = 2'd1,
		KIND_PASS     = 2'd2,
		KIND_POWER    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [FIELD_BITS-1:0] base;
		logic [FIELD_BITS-1:0] exponent;
		logic [FIELD_BITS-1:0] modulus;
	} job_t;

endpackage

>>> src/wme_front.sv
// Front end: accepts input beats, masks fields to the word width, classifies.
// Depends on wme_pkg and word_modular_exponentiation_top_defines.svh.
module wme_front #(
	parameter int WORD_BITS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  wme_pkg::in_t  in_data,
	input  logic          q_full,
	output logic          push,
	output wme_pkg::job_t job
);

	localparam logic [wme_pkg::FIELD_BITS-1:0] MASK =
		{wme_pkg::FIELD_BITS{1'b1}} >> (wme_pkg::FIELD_BITS - WORD_BITS);

	logic [wme_pkg::FIELD_BITS-1:0] e_m;
	logic [wme_pkg::FIELD_BITS-1:0] m_m;
	logic                           seen_q;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign e_m      = in_data.exponent & MASK;
	assign m_m      = in_data.modulus & MASK;

	// Classify the beat so the back end skips work for trivial cases
	always_comb begin
		job.base     = in_data.base & MASK;
		job.exponent = e_m;
		job.modulus  = m_m;
		if (m_m == '0) begin
			job.kind = wme_pkg::KIND_ZERO_MOD;
		end else if (e_m == '0) begin
			job.kind = wme_pkg::KIND_ZERO_EXP;
		end else if (e_m == wme_pkg::FIELD_BITS'(1)) begin
			job.kind = wme_pkg::KIND_PASS;
		end else begin
			job.kind = wme_pkg::KIND_POWER;
		end
	end

	// Track whether any beat has been taken since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (push) begin
			seen_q <= 1'b1;
		end
	end

	`include "word_modular_exponentiation_top_defines.svh"

	`WME_ASSERT_SAME(a_push_room, clk, arst_n, push, !q_full, "push into full queue")
	`WME_ASSERT_SAME(a_kind_mod, clk, arst_n, push && (m_m == '0), job.kind == wme_pkg::KIND_ZERO_MOD, "zero modulus misclassified")
	`WME_ASSERT_NEXT(a_seen, clk, arst_n, push, seen_q, "beat not recorded")

endmodule

>>> src/wme_queue.sv
// Two-entry job queue between front and back ends.
// Depends on wme_pkg.
module wme_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wme_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          job_valid,
	output wme_pkg::job_t job
);

	wme_pkg::job_t mem_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign job       = mem_q[rd_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> src/wme_mulmod.sv
// Bit-serial modular multiplier: r = x * y mod m, x below m, y any word.
// Depends on nothing; each bit of y is a doubling step, then an add step.
module wme_mulmod #(
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] x,
	input  logic [WORD_BITS-1:0] y,
	input  logic [WORD_BITS-1:0] m,
	output logic                 busy,
	output logic                 done,
	output logic [WORD_BITS-1:0] r
);

	localparam int CNT_BITS = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] r_q;
	logic [WORD_BITS-1:0] x_q;
	logic [WORD_BITS-1:0] y_q;
	logic [WORD_BITS-1:0] m_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 ph_q;
	logic                 busy_q;
	logic                 done_q;
	logic [WORD_BITS:0]   sum;
	logic [WORD_BITS:0]   dif;
	logic [WORD_BITS-1:0] nr;

	assign busy = busy_q;
	assign done = done_q;
	assign r    = r_q;

	// Add modulo m: double in phase 0, add x in phase 1
	always_comb begin
		sum = {1'b0, r_q} + {1'b0, (ph_q ? x_q : r_q)};
		dif = sum - {1'b0, m_q};
		nr  = (sum >= {1'b0, m_q}) ? dif[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
	end

	// Operand and result registers
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			r_q <= '0;
			x_q <= x;
			y_q <= y;
			m_q <= m;
		end else if (busy_q) begin
			if (!ph_q) begin
				r_q <= nr;
			end else begin
				if (y_q[WORD_BITS-1]) begin
					r_q <= nr;
				end
				y_q <= y_q << 1;
			end
		end
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				ph_q   <= 1'b0;
				cnt_q  <= CNT_BITS'(WORD_BITS - 1);
			end else if (busy_q) begin
				ph_q <= !ph_q;
				if (ph_q) begin
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - CNT_BITS'(1);
					end
				end
			end
		end
	end

endmodule

>>> src/wme_back.sv
// Back end: sliding-window exponentiation sequencer and output register.
// Depends on wme_pkg, wme_mulmod and word_modular_exponentiation_top_defines.svh.
module wme_back #(
	parameter int WORD_BITS   = 64,
	parameter int WINDOW_BITS = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  wme_pkg::job_t job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output wme_pkg::out_t out_data
);

	localparam int TS       = 1 << (WINDOW_BITS - 1);
	localparam int IDX_BITS = (WINDOW_BITS > 1) ? WINDOW_BITS - 1 : 1;
	localparam int REM_BITS = $clog2(WORD_BITS + 1);
	localparam int WIN_BITS = $clog2(WINDOW_BITS + 1);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_RED   = 8'b0000_0010,
		ST_SQ    = 8'b0000_0100,
		ST_TAB   = 8'b0000_1000,
		ST_FIRST = 8'b0001_0000,
		ST_SCAN  = 8'b0010_0000,
		ST_MUL   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t               state_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] m_q;
	logic [WORD_BITS-1:0] e_q;
	logic [WORD_BITS-1:0] sq_q;
	logic [WORD_BITS-1:0] tab_q [TS];
	logic [REM_BITS-1:0]  rem_q;
	logic [WIN_BITS-1:0]  pend_q;
	logic                 mpend_q;
	logic [IDX_BITS-1:0]  midx_q;
	logic [IDX_BITS-1:0]  tidx_q;
	logic                 mz_q;
	logic                 out_valid_q;
	wme_pkg::out_t        out_q;

	logic                 mm_start;
	logic [WORD_BITS-1:0] mm_x;
	logic [WORD_BITS-1:0] mm_y;
	logic [WORD_BITS-1:0] mm_m;
	logic                 mm_busy;
	logic                 mm_done;
	logic [WORD_BITS-1:0] mm_r;
	logic [WORD_BITS-1:0] job_m;
	logic [WORD_BITS-1:0] one_w;

	logic [WINDOW_BITS-1:0] top;
	logic [WINDOW_BITS-1:0] win_val;
	logic [WIN_BITS-1:0]    win_tz;
	logic [WIN_BITS-1:0]    win_size;
	logic [IDX_BITS-1:0]    win_idx;
	logic                   found;

	assign job_m     = job.modulus[WORD_BITS-1:0];
	assign one_w     = (job_m == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
	assign pop       = (state_q == ST_IDLE) && job_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Feed the first multiply the modulus of the job being popped
	assign mm_m      = (state_q == ST_IDLE) ? job_m : m_q;

	// Window at the top of the exponent: drop trailing zeros
	always_comb begin
		top    = e_q[WORD_BITS-1 -: WINDOW_BITS];
		win_tz = '0;
		found  = 1'b0;
		for (int i = 0; i < WINDOW_BITS; i++) begin
			if (!found) begin
				if (top[i]) begin
					found = 1'b1;
				end else begin
					win_tz = win_tz + WIN_BITS'(1);
				end
			end
		end
		win_size = WIN_BITS'(WINDOW_BITS) - win_tz;
		win_val  = top >> win_tz;
		win_idx  = IDX_BITS'(win_val >> 1);
	end

	// Issue multiplies
	always_comb begin
		mm_start = 1'b0;
		mm_x     = acc_q;
		mm_y     = acc_q;
		case (state_q)
			ST_IDLE: begin
				if (job_valid && (job.kind == wme_pkg::KIND_POWER)) begin
					mm_start = 1'b1;
					mm_x     = one_w;
					mm_y     = job.base[WORD_BITS-1:0];
				end
			end
			ST_RED: begin
				if (mm_done) begin
					mm_start = 1'b1;
					mm_x     = mm_r;
					mm_y     = mm_r;
				end
			end
			ST_SQ: begin
				if (mm_done && (TS > 1)) begin
					mm_start = 1'b1;
					mm_x     = tab_q[0];
					mm_y     = mm_r;
				end
			end
			ST_TAB: begin
				if (mm_done && (tidx_q != IDX_BITS'(TS - 1))) begin
					mm_start = 1'b1;
					mm_x     = mm_r;
					mm_y     = sq_q;
				end
			end
			ST_SCAN: begin
				if (pend_q != '0) begin
					mm_start = 1'b1;
				end else if (mpend_q) begin
					mm_start = 1'b1;
					mm_y     = tab_q[midx_q];
				end else if ((rem_q != '0) && !e_q[WORD_BITS-1]) begin
					mm_start = 1'b1;
				end
			end
			default: begin
				mm_start = 1'b0;
			end
		endcase
	end

	// Sequencer data path
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				m_q   <= job_m;
				e_q   <= job.exponent[WORD_BITS-1:0];
				rem_q <= REM_BITS'(WORD_BITS);
				mz_q  <= (job.kind == wme_pkg::KIND_ZERO_MOD);
				case (job.kind)
					wme_pkg::KIND_ZERO_MOD: acc_q <= '0;
					wme_pkg::KIND_ZERO_EXP: acc_q <= WORD_BITS'(1);
					default:                acc_q <= job.base[WORD_BITS-1:0];
				endcase
			end
			ST_RED: begin
				if (!e_q[WORD_BITS-1]) begin
					e_q   <= e_q << 1;
					rem_q <= rem_q - REM_BITS'(1);
				end
				if (mm_done) begin
					tab_q[0] <= mm_r;
				end
			end
			ST_SQ: begin
				if (mm_done) begin
					sq_q   <= mm_r;
					tidx_q <= IDX_BITS'(1);
				end
			end
			ST_TAB: begin
				if (mm_done) begin
					tab_q[tidx_q] <= mm_r;
					tidx_q        <= tidx_q + IDX_BITS'(1);
				end
			end
			ST_FIRST: begin
				acc_q   <= tab_q[win_idx];
				e_q     <= e_q << win_size;
				rem_q   <= rem_q - REM_BITS'(win_size);
				pend_q  <= '0;
				mpend_q <= 1'b0;
			end
			ST_SCAN: begin
				if (pend_q != '0) begin
					pend_q <= pend_q - WIN_BITS'(1);
				end else if (mpend_q) begin
					mpend_q <= 1'b0;
				end else if (rem_q != '0) begin
					if (!e_q[WORD_BITS-1]) begin
						e_q   <= e_q << 1;
						rem_q <= rem_q - REM_BITS'(1);
					end else begin
						pend_q  <= win_size;
						mpend_q <= 1'b1;
						midx_q  <= win_idx;
						e_q     <= e_q << win_size;
						rem_q   <= rem_q - REM_BITS'(win_size);
					end
				end
			end
			ST_MUL: begin
				if (mm_done) begin
					acc_q <= mm_r;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!out_valid_q || out_ready)) begin
			out_q.power_result <= wme_pkg::FIELD_BITS'(acc_q);
			out_q.modulus_zero <= mz_q;
		end
	end

	// Sequencer state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= (job.kind == wme_pkg::KIND_POWER) ? ST_RED : ST_DONE;
					end
				end
				ST_RED: begin
					if (mm_done) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (mm_done) begin
						state_q <= (TS > 1) ? ST_TAB : ST_FIRST;
					end
				end
				ST_TAB: begin
					if (mm_done && (tidx_q == IDX_BITS'(TS - 1))) begin
						state_q <= ST_FIRST;
					end
				end
				ST_FIRST: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (mm_start) begin
						state_q <= ST_MUL;
					end else if ((pend_q == '0) && !mpend_q && (rem_q == '0)) begin
						state_q <= ST_DONE;
					end
				end
				ST_MUL: begin
					if (mm_done) begin
						state_q <= ST_SCAN;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	wme_mulmod #(
		.WORD_BITS(WORD_BITS)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mm_start),
		.x     (mm_x),
		.y     (mm_y),
		.m     (mm_m),
		.busy  (mm_busy),
		.done  (mm_done),
		.r     (mm_r)
	);

	`include "word_modular_exponentiation_top_defines.svh"

	`WME_ASSERT_SAME(a_start_idle, clk, arst_n, mm_start, !mm_busy, "multiply issued while busy")
	`WME_ASSERT_SAME(a_norm, clk, arst_n, (state_q == ST_RED) && mm_done, e_q[WORD_BITS-1], "exponent not normalized")
	`WME_ASSERT_NEXT(a_finish, clk, arst_n, (state_q == ST_SCAN) && !mm_start && (pend_q == '0) && !mpend_q && (rem_q == '0), state_q == ST_DONE, "scan did not finish")

endmodule

>>> src/word_modular_exponentiation_top.sv
// Channel | Signals                        | Beat carries
// in      | in_valid, in_ready, in_data    | base, exponent, modulus
// out     | out_valid, out_ready, out_data | power_result, modulus_zero
// One item at a time in the back end; every modular product runs on one
// bit-serial multiplier shared by all steps of a power.
// Zero modulus, zero exponent and exponent one go to the output without a multiply.
// A two-entry queue lets the front accept beats while the back end computes.
// Reset clears control only; out_ready low holds the result in the output register.
// Top level of the word modular exponentiation block; depends on wme_pkg,
// wme_front, wme_queue, wme_back.
module word_modular_exponentiation_top #(
	parameter int WORD_BITS   = 64,
	parameter int WINDOW_BITS = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  wme_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output wme_pkg::out_t out_data
);

	logic          q_full;
	logic          push;
	wme_pkg::job_t push_job;
	logic          pop;
	logic          job_valid;
	wme_pkg::job_t job;

	wme_front #(
		.WORD_BITS(WORD_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data (in_data),
		.q_full  (q_full),
		.push    (push),
		.job     (push_job)
	);

	wme_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.job_valid(job_valid),
		.job      (job)
	);

	wme_back #(
		.WORD_BITS  (WORD_BITS),
		.WINDOW_BITS(WINDOW_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job      (job),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

>>> tb/tb_word_modular_exponentiation_top.sv
// Testbench for word_modular_exponentiation_top: directed and random beats,
// results predicted by a sliding-window model and checked in order.
// Depends on wme_pkg and the word_modular_exponentiation_top RTL.
`timescale 1ns / 100ps

module tb_word_modular_exponentiation_top;

	localparam int WORD_BITS   = 64;
	localparam int WINDOW_BITS = 3;
	localparam int TAB_SIZE    = 1 << (WINDOW_BITS - 1);
	localparam int N_RANDOM    = 700;
	// longest power: up to ~90 products
	localparam int STALL_LIMIT = 200000;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	wme_pkg::in_t  in_data;
	logic          out_valid;
	logic          out_ready;
	wme_pkg::out_t out_data;

	int   fail_count;
	int   idle_cycles;
	bit   stim_done;

	word_modular_exponentiation_top #(
		.WORD_BITS  (WORD_BITS),
		.WINDOW_BITS(WINDOW_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// Report one mismatch and count it
	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// Modular product at double width
	function automatic logic [63:0] mul_mod(input logic [63:0] x, input logic [63:0] y,
			input logic [63:0] m);
		logic [127:0] p;
		p = {64'd0, x} * {64'd0, y};
		return 64'(p % {64'd0, m});
	endfunction

	// True when pos holds the top set bit of e
	function automatic bit first_window(input logic [63:0] e, input int pos);
		return (e >> pos) == 64'd1;
	endfunction

	// Predict base^exponent mod modulus with a WINDOW_BITS window and TAB_SIZE odd powers
	function automatic wme_pkg::out_t predict_power(input wme_pkg::in_t beat);
		wme_pkg::out_t r;
		logic [63:0] a, e, m, sq, acc;
		logic [63:0] odd_pow [TAB_SIZE];
		int pos, size;
		int unsigned win;
		a = beat.base;
		e = beat.exponent;
		m = beat.modulus;
		r = '0;
		if (m == 0) begin
			r.modulus_zero = 1'b1;
			return r;
		end
		if (e == 0) begin
			r.power_result = 64'd1;
			return r;
		end
		sq = mul_mod(a % m, a % m, m);
		odd_pow[0] = a;
		for (int i = 1; i < TAB_SIZE; i++) begin
			odd_pow[i] = mul_mod(odd_pow[i-1] % m, sq, m);
		end
		pos = 63;
		while (e[pos] == 1'b0) pos--;
		acc = 0;
		size = 0;
		while (pos >= 0) begin
			if (size != 0 && e[pos] == 1'b0) begin
				acc = mul_mod(acc, acc, m);
				pos--;
			end else begin
				// take the window, drop trailing zeros
				size = (pos + 1 < WINDOW_BITS) ? pos + 1 : WINDOW_BITS;
				win = 0;
				for (int k = 0; k < size; k++) win = (win << 1) | e[pos - k];
				while (size > 1 && win[0] == 1'b0) begin
					win >>= 1;
					size--;
				end
				if (pos == 63 || acc === 64'd0 && pos >= 0 && size != 0 && first_window(e, pos))
					acc = odd_pow[(win >> 1) % TAB_SIZE];
				else begin
					for (int k = 0; k < size; k++) acc = mul_mod(acc, acc, m);
					acc = mul_mod(acc % m, odd_pow[(win >> 1) % TAB_SIZE] % m, m);
				end
				pos -= size;
			end
		end
		r.power_result = acc;
		return r;
	endfunction

	// Scoreboard of predicted results, oldest first
	class power_scoreboard;
		wme_pkg::out_t pending[$];

		function void note_input(input wme_pkg::in_t beat);
			pending.push_back(predict_power(beat));
		endfunction

		task check_result(input wme_pkg::out_t got);
			wme_pkg::out_t want;
			if (pending.size() == 0) begin
				report_error($sformatf("unexpected result %h", got));
				return;
			end
			want = pending.pop_front();
			if (got.power_result !== want.power_result)
				report_error($sformatf("power_result %h, expected %h",
					got.power_result, want.power_result));
			if (got.modulus_zero !== want.modulus_zero)
				report_error($sformatf("modulus_zero %b, expected %b",
					got.modulus_zero, want.modulus_zero));
		endtask
	endclass

	power_scoreboard sb;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Send one beat after a random gap; valid drops only while idling
	task automatic send_beat(input logic [63:0] b, input logic [63:0] e,
			input logic [63:0] m);
		int gap;
		gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{base: b, exponent: e, modulus: m};
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// Random word with its width drawn so small and large values both show up
	function automatic logic [63:0] rand_sized();
		int w;
		w = $urandom_range(1, 64);
		return rand_word() >> (64 - w);
	endfunction

	// Note accepted beats, check results
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_input(in_data);
			if (out_valid && out_ready) sb.check_result(out_data);
		end
	end

	// Drive out_ready with random stalls
	initial begin
		int wait_n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			if (wait_n > 0) begin
				out_ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Watchdog on cycles with no accepted beat or result
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Stimulus
	initial begin
		logic [63:0] b, e, m;
		sb = new();
		fail_count  = 0;
		idle_cycles = 0;
		stim_done   = 1'b0;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero modulus, zero exponent, exponent one, big base, extremes
		send_beat(64'd5, 64'd7, 64'd0);
		send_beat('1, '1, 64'd0);
		send_beat(64'd9, 64'd0, 64'd1);
		send_beat('1, 64'd0, '1);
		send_beat('1, 64'd1, 64'd7);
		send_beat(64'd3, 64'd1, '1);
		send_beat('1, 64'd2, 64'd13);
		send_beat(64'd100, 64'd5, 64'd7);
		send_beat(64'd2, '1, '1);
		send_beat('1, '1, '1);
		send_beat('1, '1, 64'd1);
		send_beat(64'd0, 64'd10, 64'd11);
		send_beat(64'd3, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFC5);
		send_beat(64'd7, 64'b1011_0111_0001, 64'd1000003);
		send_beat(64'hDEAD_BEEF_1234_5678, 64'h5555_5555_5555_5555,
			64'h8000_0000_0000_0001);
		send_beat(64'd12345, 64'd6, 64'd2);
		send_beat(64'd12345, 64'd3, 64'd1);

		// random beats: mostly short exponents, some full words
		for (int n = 0; n < N_RANDOM; n++) begin
			b = ($urandom_range(0, 1)) ? rand_word() : rand_sized();
			e = ($urandom_range(0, 4) == 0) ? rand_word() : rand_sized() >> 48;
			case ($urandom_range(0, 19))
				0:       m = 64'd0;
				1:       m = 64'd1;
				2:       m = '1;
				default: m = ($urandom_range(0, 1)) ? rand_word() : rand_sized();
			endcase
			if ($urandom_range(0, 19) == 0) e = $urandom_range(0, 1);
			send_beat(b, e, m);
		end
		in_valid <= 1'b0;

		// drain
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/wme_pkg.sv
src/wme_front.sv
src/wme_queue.sv
src/wme_mulmod.sv
src/wme_back.sv
src/word_modular_exponentiation_top.sv
tb/tb_word_modular_exponentiation_top.sv
